// ===== rtl/bsbi_pkg.sv =====
// Shared types and constants for the bounded stack with bottom increment.
`timescale 1ns / 1ps
package bsbi_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int CAP_W     = 7;
  localparam int DATA_W    = 32;
  localparam int KCNT_W    = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // request kinds
  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_INC  = 2'd2;

  // per-cell operations broadcast along the row
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_PUSH = 2'd1;
  localparam logic [1:0] CELL_POP  = 2'd2;
  localparam logic [1:0] CELL_ADD  = 2'd3;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] push_value;
    logic [KCNT_W-1:0]        bottom_count;
    logic signed [DATA_W-1:0] add_amount;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic                     was_empty;
  } rsp_t;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] amount;
  } cell_cmd_t;

endpackage

// ===== rtl/bounded_stack_with_bottom_increment_core.sv =====
// Top level: bounded LIFO stack as a row of cells with bottom increment.
// Each request is taken by a start transfer and then runs in one execute
// cycle in which busy is high and every cell shifts toward or away from
// the top, or the cells of the bottom kcnt entries add the amount, all in
// parallel. A pop shows its result with result_valid for exactly one cycle
// right after busy falls; start is taken again in that same cycle, but
// not while busy is high. The receiver has no way to stall a result.
// The top of the stack sits in cell 0; no clearing pass follows reset.
`timescale 1ns / 1ps
module bounded_stack_with_bottom_increment_core #(
  parameter int DEPTH = bsbi_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  bsbi_pkg::req_t               req,
  input  logic                         cfg_we,
  input  logic [bsbi_pkg::CAP_W-1:0]   cfg_wdata,
  output logic                         result_valid,
  output bsbi_pkg::rsp_t               result
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [bsbi_pkg::CAP_W-1:0] capacity;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  logic [CNT_W-1:0]           kcnt;
  bsbi_pkg::req_t             req_q;
  bsbi_pkg::cell_cmd_t        cmd;
  logic                       push_ok;
  logic                       empty;

  logic signed [bsbi_pkg::DATA_W-1:0] cell_val [DEPTH];

  assign empty   = (count == '0);
  assign push_ok = (bsbi_pkg::KCNT_W'(count) < bsbi_pkg::KCNT_W'(capacity)) &&
                   (bsbi_pkg::KCNT_W'(count) < bsbi_pkg::KCNT_W'(DEPTH));
  assign kcnt    = (req_q.bottom_count > bsbi_pkg::KCNT_W'(count)) ? count
                   : req_q.bottom_count[CNT_W-1:0];

  always_comb begin
    cmd.amount = req_q.add_amount;
    cmd.op     = bsbi_pkg::CELL_HOLD;
    count_next = count;
    if (busy) begin
      case (req_q.req_type)
        bsbi_pkg::REQ_PUSH: begin
          if (push_ok) begin
            cmd.op     = bsbi_pkg::CELL_PUSH;
            count_next = count + CNT_W'(1);
          end
        end
        bsbi_pkg::REQ_POP: begin
          if (!empty) begin
            cmd.op     = bsbi_pkg::CELL_POP;
            count_next = count - CNT_W'(1);
          end
        end
        bsbi_pkg::REQ_INC: cmd.op = bsbi_pkg::CELL_ADD;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= bsbi_pkg::CAP_RESET;
      count        <= '0;
      busy         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      count        <= count_next;
      result_valid <= busy && (req_q.req_type == bsbi_pkg::REQ_POP);
      // hold busy for exactly the execute cycle
      busy         <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
    if (busy) begin
      result.popped_value <= empty ? -32'sd1 : cell_val[0];
      result.was_empty    <= empty;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [bsbi_pkg::DATA_W-1:0] up_val;
    logic signed [bsbi_pkg::DATA_W-1:0] down_val;

    if (i == 0) begin : g_top
      assign up_val = req_q.push_value;
    end else begin : g_mid
      assign up_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_bot
      assign down_val = '0;
    end else begin : g_low
      assign down_val = cell_val[i+1];
    end

    bsbi_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .from_up   (up_val),
      .from_down (down_val),
      .count     (count),
      .kcnt      (kcnt),
      .value     (cell_val[i])
    );
  end

endmodule

// ===== rtl/bsbi_cell.sv =====
// One stack cell: holds one entry, shifts with its neighbors or adds in place.
`timescale 1ns / 1ps
module bsbi_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic                               clk,
  input  bsbi_pkg::cell_cmd_t                cmd,
  input  logic signed [bsbi_pkg::DATA_W-1:0] from_up,
  input  logic signed [bsbi_pkg::DATA_W-1:0] from_down,
  input  logic [CNT_W-1:0]                   count,
  input  logic [CNT_W-1:0]                   kcnt,
  output logic signed [bsbi_pkg::DATA_W-1:0] value
);

  logic              in_range;
  logic [CNT_W:0]    reach;

  // cell INDEX holds depth position count-1-INDEX; it is among the bottom
  // kcnt entries when INDEX < count and INDEX + kcnt >= count
  assign reach    = (CNT_W+1)'(INDEX) + {1'b0, kcnt};
  assign in_range = ({1'b0, count} > (CNT_W+1)'(INDEX)) && (reach >= {1'b0, count});

  always_ff @(posedge clk) begin
    case (cmd.op)
      bsbi_pkg::CELL_PUSH: value <= from_up;
      bsbi_pkg::CELL_POP:  value <= from_down;
      bsbi_pkg::CELL_ADD: begin
        if (in_range) begin
          value <= value + cmd.amount;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/bsbi_checker.sv =====
// Port-level checker for the stack core, bound to the top level.
`timescale 1ns / 1ps
module bsbi_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           result_valid,
  input bsbi_pkg::rsp_t result
);

  // a transfer on start opens exactly one execute cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    !rst && start && !busy |=> busy)
    else $error("busy did not follow an accepted request");

  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // a result only ever follows an execute cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy) && !busy)
    else $error("result without a preceding execute cycle");

  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.was_empty |-> result.popped_value == -32'sd1)
    else $error("empty pop did not return minus one");

endmodule

bind bounded_stack_with_bottom_increment_core bsbi_checker u_bsbi_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the bounded stack with bottom increment.
`timescale 1ns / 1ps
module tb_top;
  import bsbi_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int STALL_LIMIT = 400;
  localparam int MAX_REPORTS = 10;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 req = '0;
  logic                 cfg_we = 1'b0;
  logic [CAP_W-1:0]     cfg_wdata = '0;
  logic                 result_valid;
  rsp_t                 result;

  bounded_stack_with_bottom_increment_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .result       (result)
  );

  always #2 clk = ~clk;

  // stack mirror, bottom at index 0
  logic signed [DATA_W-1:0] stack_mirror [0:DEPTH-1];
  int                       mirror_count = 0;
  int                       mirror_cap = int'(CAP_RESET);

  req_t pending_reqs [$];
  rsp_t expected_pops [$];
  int   mismatch_count = 0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   stall_cycles = 0;

  task automatic apply_request(input req_t r);
    int   room;
    int   k;
    rsp_t e;
    case (r.req_type)
      REQ_PUSH: begin
        room = (mirror_cap > DEPTH) ? DEPTH : mirror_cap;
        if (mirror_count < room) begin
          stack_mirror[mirror_count] = r.push_value;
          mirror_count++;
        end
      end
      REQ_POP: begin
        if (mirror_count == 0) begin
          e.popped_value = -1;
          e.was_empty    = 1'b1;
        end else begin
          mirror_count--;
          e.popped_value = stack_mirror[mirror_count];
          e.was_empty    = 1'b0;
        end
        expected_pops.push_back(e);
      end
      REQ_INC: begin
        k = (int'(r.bottom_count) > mirror_count) ? mirror_count : int'(r.bottom_count);
        for (int i = 0; i < k; i++) stack_mirror[i] = stack_mirror[i] + r.add_amount;
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input rsp_t exp_r, input rsp_t act_r);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("ERROR %s: expected value %0d empty %0b, got value %0d empty %0b",
               what, exp_r.popped_value, exp_r.was_empty, act_r.popped_value, act_r.was_empty);
  endtask

  // driver: issue queued requests in bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) apply_request(req);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req   <= pending_reqs.pop_front();
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every pop result must match the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_pops.size() == 0) begin
        note_mismatch("unexpected pop result", '0, result);
      end else begin
        if (result.popped_value !== expected_pops[0].popped_value ||
            result.was_empty !== expected_pops[0].was_empty)
          note_mismatch("pop result", expected_pops[0], result);
        void'(expected_pops.pop_front());
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("bounded_stack_with_bottom_increment_core: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_req(input logic [1:0] kind, input logic [DATA_W-1:0] pval,
                           input logic [KCNT_W-1:0] kcnt, input logic [DATA_W-1:0] amt);
    req_t r;
    r.req_type     = kind;
    r.push_value   = pval;
    r.bottom_count = kcnt;
    r.add_amount   = amt;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || start || expected_pops.size() != 0);
    // let the execute cycle of a trailing push or increment finish
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CAP_W'(value);
    mirror_cap = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(input int n, input int push_pct, input int pop_pct);
    int               roll;
    logic [KCNT_W-1:0] kcnt;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0, 1:    kcnt = KCNT_W'($urandom);
        2, 3, 4: kcnt = KCNT_W'($urandom_range(0, 3));
        default: kcnt = KCNT_W'($urandom_range(0, 68));
      endcase
      if (roll < push_pct)
        queue_req(REQ_PUSH, $urandom, kcnt, $urandom);
      else if (roll < push_pct + pop_pct)
        queue_req(REQ_POP, $urandom, kcnt, $urandom);
      else if (roll < 97)
        queue_req(REQ_INC, $urandom, kcnt, $urandom);
      else
        queue_req(2'd3, $urandom, kcnt, $urandom);
    end
  endtask

  initial begin
    int caps [10];
    int push_pcts [10];
    caps      = '{3, 0, 64, 1, 20, 100, 64, 7, 45, 64};
    push_pcts = '{60, 50, 55, 45, 70, 65, 40, 60, 75, 35};
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // edge values, wrap-around and bottom-count clamping at default capacity
    queue_req(REQ_POP, 32'h0, 16'h0, 32'h0);
    queue_req(REQ_PUSH, 32'h7FFF_FFFF, 16'h0, 32'h0);
    queue_req(REQ_PUSH, 32'h8000_0000, 16'hFFFF, 32'hFFFF_FFFF);
    queue_req(REQ_PUSH, 32'h0, 16'h0, 32'h0);
    queue_req(REQ_PUSH, 32'hFFFF_FFFF, 16'h0, 32'h0);
    queue_req(REQ_INC, 32'h0, 16'h0, 32'h5);
    queue_req(REQ_INC, 32'h0, 16'hFFFF, 32'h1);
    queue_req(REQ_INC, 32'h0, 16'h2, 32'h8000_0000);
    queue_req(2'd3, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    repeat (5) queue_req(REQ_POP, 32'h0, 16'h0, 32'h0);
    queue_req(REQ_PUSH, 32'h1234_5678, 16'h0, 32'h0);
    queue_req(REQ_INC, 32'h0, 16'h1, 32'h7FFF_FFFF);
    queue_req(REQ_POP, 32'h0, 16'h0, 32'h0);
    wait_drained();

    // zero capacity drops every push
    write_capacity(0);
    queue_req(REQ_PUSH, 32'hA5A5_A5A5, 16'h0, 32'h0);
    queue_req(REQ_PUSH, 32'h5A5A_5A5A, 16'h0, 32'h0);
    queue_req(REQ_POP, 32'h0, 16'h0, 32'h0);
    wait_drained();

    // capacity beyond the depth: fill to the top, overflow, then pop a few
    write_capacity(127);
    repeat (DEPTH + 3) queue_req(REQ_PUSH, $urandom, 16'h0, 32'h0);
    queue_req(REQ_INC, 32'h0, 16'd64, $urandom);
    repeat (4) queue_req(REQ_POP, 32'h0, 16'h0, 32'h0);
    wait_drained();

    // random phases; the first lowers the capacity below the current count
    for (int p = 0; p < 10; p++) begin
      write_capacity(caps[p]);
      queue_random(100, push_pcts[p], 85 - push_pcts[p]);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_pops.size() == 0) begin
      $display("bounded_stack_with_bottom_increment_core: match");
    end else begin
      $display("bounded_stack_with_bottom_increment_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bsbi_pkg.sv
rtl/bsbi_cell.sv
rtl/bounded_stack_with_bottom_increment_core.sv
rtl/bsbi_checker.sv
verif/tb_top.sv
